// ===== design/rz_field_map_bilinear_interp_core_defines.svh =====
// ----------------------------------------------------------------------------
// rz field map core assertion macros
// shared property wrappers for the field map lookup design
// ----------------------------------------------------------------------------
`ifndef RZ_FIELD_MAP_BILINEAR_INTERP_CORE_DEFINES_SVH
`define RZ_FIELD_MAP_BILINEAR_INTERP_CORE_DEFINES_SVH

// same-cycle implication under active-low reset
`define RZFM_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// next-cycle implication under active-low reset
`define RZFM_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/rzfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rzfm_pkg
// shared constants, types and helpers of the rz field map lookup core
// ----------------------------------------------------------------------------
package rzfm_pkg;

  localparam int R_POINTS_DEF = 64;
  localparam int Z_POINTS_DEF = 161;

  localparam int POS_W   = 31;
  localparam int ZPOS_W  = 32;
  localparam int IDX_W   = 14;
  localparam int FLD_W   = 32;
  localparam int STEP_W  = 24;
  localparam int RECIP_W = 32;
  localparam int AREA_W  = 48;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int ENT_W   = 3 * FLD_W;
  localparam int GEO_W   = 48;

  // pipeline stages, stage that reads and writes the tables
  localparam int NSTG    = 17;
  localparam int STG_MEM = 4;

  localparam logic [POS_W-1:0]   R_MAX_RST   = 31'd2304000;
  localparam logic [POS_W-1:0]   Z_MAX_RST   = 31'd4096000;
  localparam logic [STEP_W-1:0]  R_STEP_RST  = 24'd51200;
  localparam logic [STEP_W-1:0]  Z_STEP_RST  = 24'd51200;
  localparam logic [RECIP_W-1:0] R_RECIP_RST = 32'd83886;
  localparam logic [RECIP_W-1:0] Z_RECIP_RST = 32'd83886;
  localparam logic [AREA_W-1:0]  AREA_RST    = 48'd107374;

  localparam logic [FLD_W-1:0] FLD_MAX = 32'h7FFF_FFFF;
  localparam logic [FLD_W-1:0] FLD_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R_MAX   = 3'd0,
    REG_Z_MAX   = 3'd1,
    REG_R_STEP  = 3'd2,
    REG_Z_STEP  = 3'd3,
    REG_R_RECIP = 3'd4,
    REG_Z_RECIP = 3'd5,
    REG_AREA    = 3'd6
  } cfg_reg_e;

  // [0] radial, [1] azimuthal, [2] axial
  typedef logic [2:0][FLD_W-1:0] fld3_t;
  typedef fld3_t [3:0] quad_t;

  typedef struct packed {
    logic [NSTG:1] en;
    logic [NSTG:1] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [3:0] we;
    logic       re;
  } ram_ctl_t;

  function automatic int clog2_min1(input int n);
    int w;
    w = $clog2(n);
    return (w < 1) ? 1 : w;
  endfunction

  function automatic int bank_depth(input int r_pts, input int z_pts);
    return ((r_pts + 1) / 2) * ((z_pts + 1) / 2);
  endfunction

endpackage

// ===== design/rzfm_in_if.sv =====
// ----------------------------------------------------------------------------
// rzfm_in_if
// input channel: load and lookup beats
// ----------------------------------------------------------------------------
interface rzfm_in_if;
  import rzfm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [POS_W-1:0]         radius;
  logic signed [ZPOS_W-1:0] z_pos;
  logic [IDX_W-1:0]         entry_index;
  logic signed [FLD_W-1:0]  entry_radial;
  logic signed [FLD_W-1:0]  entry_azimuthal;
  logic signed [FLD_W-1:0]  entry_axial;

  modport source (
    output valid, command, radius, z_pos, entry_index,
           entry_radial, entry_azimuthal, entry_axial,
    input  ready
  );

  modport sink (
    input  valid, command, radius, z_pos, entry_index,
           entry_radial, entry_azimuthal, entry_axial,
    output ready
  );
endinterface

// ===== design/rzfm_out_if.sv =====
// ----------------------------------------------------------------------------
// rzfm_out_if
// result channel: interpolated field beats
// ----------------------------------------------------------------------------
interface rzfm_out_if;
  import rzfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [FLD_W-1:0] field_radial;
  logic signed [FLD_W-1:0] field_azimuthal;
  logic signed [FLD_W-1:0] field_axial;

  modport source (
    output valid, field_radial, field_azimuthal, field_axial,
    input  ready
  );

  modport sink (
    input  valid, field_radial, field_azimuthal, field_axial,
    output ready
  );
endinterface

// ===== design/rz_field_map_bilinear_interp_core.sv =====
// ----------------------------------------------------------------------------
// rz_field_map_bilinear_interp_core
// banked rz field map with bilinear lookup, without back-pressure one beat per cycle
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    command, radius, z_pos, entry_index, entries
//  result_o  out  valid/ready    field_radial, field_azimuthal, field_axial
//  cfg       in   cfg_we_i       cfg_index_i, cfg_wdata_i
//
// one beat per cycle sustained while results are taken; lookups pass every stage.
// the four cell corners sit in four parity banks, so each bank serves one
// read and one write port per cycle and a lookup needs one access per bank.
// tables come out of reset unwritten; there is no clearing pass.
// each stage moves when the next one is free, so a held result stalls
// only the stages behind it that are full.
`include "rz_field_map_bilinear_interp_core_defines.svh"

module rz_field_map_bilinear_interp_core #(
  parameter int R_POINTS = rzfm_pkg::R_POINTS_DEF,
  parameter int Z_POINTS = rzfm_pkg::Z_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rzfm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rzfm_pkg::CFG_W-1:0]        cfg_wdata_i,
  rzfm_in_if.sink                           item_i,
  rzfm_out_if.source                        result_o
);
  import rzfm_pkg::*;

  localparam int BANK_DEPTH = bank_depth(R_POINTS, Z_POINTS);
  localparam int AW         = clog2_min1(BANK_DEPTH);

  // configuration registers
  logic [POS_W-1:0]   r_max_q, z_max_q;
  logic [STEP_W-1:0]  r_step_q, z_step_q;
  logic [RECIP_W-1:0] r_recip_q, z_recip_q;
  logic [AREA_W-1:0]  area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_max_q   <= R_MAX_RST;
      z_max_q   <= Z_MAX_RST;
      r_step_q  <= R_STEP_RST;
      z_step_q  <= Z_STEP_RST;
      r_recip_q <= R_RECIP_RST;
      z_recip_q <= Z_RECIP_RST;
      area_q    <= AREA_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_R_MAX:   r_max_q   <= cfg_wdata_i[POS_W-1:0];
        REG_Z_MAX:   z_max_q   <= cfg_wdata_i[POS_W-1:0];
        REG_R_STEP:  r_step_q  <= cfg_wdata_i[STEP_W-1:0];
        REG_Z_STEP:  z_step_q  <= cfg_wdata_i[STEP_W-1:0];
        REG_R_RECIP: r_recip_q <= cfg_wdata_i[RECIP_W-1:0];
        REG_Z_RECIP: z_recip_q <= cfg_wdata_i[RECIP_W-1:0];
        REG_AREA:    area_q    <= cfg_wdata_i[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid chain with per-stage advance
  logic [NSTG:1]   vld_q, vin;
  logic [NSTG+1:1] en;
  logic            lkp3;
  pipe_ctrl_t      ctrl;

  always_comb begin
    en[NSTG+1] = result_o.ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vin[1] = item_i.valid;
    for (int k = 2; k <= NSTG; k++) begin
      vin[k] = vld_q[k-1];
    end
    // loads end at the table write
    vin[STG_MEM] = vld_q[STG_MEM-1] && lkp3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign ctrl.en  = en[NSTG:1];
  assign ctrl.vld = vld_q;

  assign item_i.ready   = en[1];
  assign result_o.valid = vld_q[NSTG];

  // stage 1 input capture
  logic                cmd1_q;
  logic [POS_W-1:0]    rad1_q;
  logic [ZPOS_W-1:0]   zpos1_q;
  logic [IDX_W-1:0]    idx1_q;
  fld3_t               ent1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd1_q  <= item_i.command;
      rad1_q  <= item_i.radius;
      zpos1_q <= item_i.z_pos;
      idx1_q  <= item_i.entry_index;
      ent1_q  <= {item_i.entry_axial, item_i.entry_azimuthal, item_i.entry_radial};
    end
  end

  ram_ctl_t                 ram_ctl;
  logic [AW-1:0]            waddr;
  fld3_t                    wdata;
  logic [3:0][AW-1:0]       raddr;
  quad_t                    rdata;
  logic signed [GEO_W-1:0]  pos_r, pos_z, low_r, low_z;
  logic [1:0]               par;
  fld3_t                    res;

  rzfm_locate #(
    .R_POINTS (R_POINTS),
    .Z_POINTS (Z_POINTS)
  ) u_locate (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .cmd_i     (cmd1_q),
    .rad_i     (rad1_q),
    .zpos_i    (zpos1_q),
    .idx_i     (idx1_q),
    .ent_i     (ent1_q),
    .r_max_i   (r_max_q),
    .z_max_i   (z_max_q),
    .r_step_i  (r_step_q),
    .z_step_i  (z_step_q),
    .r_recip_i (r_recip_q),
    .z_recip_i (z_recip_q),
    .lkp3_o    (lkp3),
    .ram_o     (ram_ctl),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_o   (raddr),
    .pos_r_o   (pos_r),
    .pos_z_o   (pos_z),
    .low_r_o   (low_r),
    .low_z_o   (low_z),
    .par_o     (par)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    rzfm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (ram_ctl.we[b]),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (ram_ctl.re),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  rzfm_blend u_blend (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pos_r_i  (pos_r),
    .pos_z_i  (pos_z),
    .low_r_i  (low_r),
    .low_z_i  (low_z),
    .par_i    (par),
    .bank_i   (rdata),
    .r_step_i (r_step_q),
    .z_step_i (z_step_q),
    .area_i   (area_q),
    .res_o    (res)
  );

  assign result_o.field_radial    = res[0];
  assign result_o.field_azimuthal = res[1];
  assign result_o.field_axial     = res[2];

  `RZFM_ASSERT_NOW(a_full_stall, clk_i, rst_ni, !item_i.ready, result_o.valid && !result_o.ready, "input blocked while output drains")
  `RZFM_ASSERT_NOW(a_rw_excl, clk_i, rst_ni, ram_ctl.re, ram_ctl.we == 4'b0000, "table read and write in one cycle")
  `RZFM_ASSERT_NOW(a_one_bank, clk_i, rst_ni, 1'b1, $onehot0(ram_ctl.we), "load beat writes more than one bank")
  `RZFM_ASSERT_NEXT(a_read_lands, clk_i, rst_ni, ram_ctl.re, vld_q[STG_MEM], "table read without a lookup in the read stage")
endmodule

// ===== design/rzfm_ram.sv =====
// ----------------------------------------------------------------------------
// rzfm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rzfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/rzfm_locate.sv =====
// ----------------------------------------------------------------------------
// rzfm_locate
// clamps the position, finds the grid cell and drives the banked tables
// ----------------------------------------------------------------------------
module rzfm_locate #(
  parameter int R_POINTS = rzfm_pkg::R_POINTS_DEF,
  parameter int Z_POINTS = rzfm_pkg::Z_POINTS_DEF,
  localparam int AW = rzfm_pkg::clog2_min1(rzfm_pkg::bank_depth(R_POINTS, Z_POINTS))
) (
  input  logic                            clk_i,
  input  rzfm_pkg::pipe_ctrl_t            ctrl_i,
  input  logic                            cmd_i,
  input  logic [rzfm_pkg::POS_W-1:0]      rad_i,
  input  logic [rzfm_pkg::ZPOS_W-1:0]     zpos_i,
  input  logic [rzfm_pkg::IDX_W-1:0]      idx_i,
  input  rzfm_pkg::fld3_t                 ent_i,
  input  logic [rzfm_pkg::POS_W-1:0]      r_max_i,
  input  logic [rzfm_pkg::POS_W-1:0]      z_max_i,
  input  logic [rzfm_pkg::STEP_W-1:0]     r_step_i,
  input  logic [rzfm_pkg::STEP_W-1:0]     z_step_i,
  input  logic [rzfm_pkg::RECIP_W-1:0]    r_recip_i,
  input  logic [rzfm_pkg::RECIP_W-1:0]    z_recip_i,
  output logic                            lkp3_o,
  output rzfm_pkg::ram_ctl_t              ram_o,
  output logic [AW-1:0]                   waddr_o,
  output rzfm_pkg::fld3_t                 wdata_o,
  output logic [3:0][AW-1:0]              raddr_o,
  output logic signed [rzfm_pkg::GEO_W-1:0] pos_r_o,
  output logic signed [rzfm_pkg::GEO_W-1:0] pos_z_o,
  output logic signed [rzfm_pkg::GEO_W-1:0] low_r_o,
  output logic signed [rzfm_pkg::GEO_W-1:0] low_z_o,
  output logic [1:0]                      par_o
);
  import rzfm_pkg::*;

  localparam int RW    = clog2_min1(R_POINTS);
  localparam int ZW    = clog2_min1(Z_POINTS);
  localparam int ZH    = (Z_POINTS + 1) / 2;
  localparam int HALF  = (Z_POINTS - 1) / 2;
  localparam int DEPTH = R_POINTS * Z_POINTS;
  // entry index split by reciprocal multiply, off by at most one
  localparam int QS    = 2 * IDX_W;
  localparam int ZRECIP_I = (1 << QS) / Z_POINTS;
  localparam logic [QS-1:0] ZRECIP = QS'(ZRECIP_I);

  // stage 2
  logic [POS_W-1:0]         rc;
  logic signed [32:0]       zs, zmx, zlo, zc, zc_neg;
  logic [30:0]              zmag;
  logic [POS_W-1:0]         rc2_q;
  logic signed [32:0]       zc2_q;
  logic [62:0]              rprod2_q, zprod2_q;
  logic                     zneg2_q, cmd2_q;
  logic [IDX_W-1:0]         idx2_q;
  logic [IDX_W+QS-1:0]      qprod2_q;
  fld3_t                    ent2_q;

  always_comb begin
    rc     = (rad_i > r_max_i) ? r_max_i : rad_i;
    zs     = $signed({zpos_i[ZPOS_W-1], zpos_i});
    zmx    = $signed({2'b00, z_max_i});
    zlo    = -zmx;
    zc     = (zs > zmx) ? zmx : ((zs < zlo) ? zlo : zs);
    zc_neg = -zc;
    zmag   = zc[32] ? zc_neg[30:0] : zc[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      rc2_q    <= rc;
      zc2_q    <= zc;
      rprod2_q <= 63'(rc) * 63'(r_recip_i);
      zprod2_q <= 63'(zmag) * 63'(z_recip_i);
      zneg2_q  <= zc[32];
      cmd2_q   <= cmd_i;
      idx2_q   <= idx_i;
      qprod2_q <= (IDX_W+QS)'(idx_i) * (IDX_W+QS)'(ZRECIP);
      ent2_q   <= ent_i;
    end
  end

  // stage 3
  logic [30:0]              rq;
  logic [RW-1:0]            rcell;
  logic [63:0]              zsum;
  logic [31:0]              zq;
  logic signed [34:0]       zq_s, zcs;
  logic [ZW-1:0]            zcell;
  logic [IDX_W-1:0]         q0, rem, lr, lz;
  logic                     fix, lok;

  logic [RW-1:0]            rcell3_q, lr3_q;
  logic [ZW-1:0]            zcell3_q, lz3_q;
  logic [POS_W-1:0]         rc3_q;
  logic signed [32:0]       zc3_q;
  logic                     cmd3_q, lok3_q;
  fld3_t                    ent3_q;

  always_comb begin
    rq    = rprod2_q[62:32];
    rcell = (rq > 31'(R_POINTS - 2)) ? RW'(R_POINTS - 2) : rq[RW-1:0];
    // negative z rounds the cell toward minus infinity
    zsum  = 64'(zprod2_q) + 64'h0000_0000_FFFF_FFFF;
    zq    = zneg2_q ? zsum[63:32] : {1'b0, zprod2_q[62:32]};
    zq_s  = $signed({3'b000, zq});
    zcs   = (zneg2_q ? -zq_s : zq_s) + 35'(HALF);
    if (zcs < 0) begin
      zcell = '0;
    end else if (zcs > 35'(Z_POINTS - 2)) begin
      zcell = ZW'(Z_POINTS - 2);
    end else begin
      zcell = zcs[ZW-1:0];
    end
    q0  = qprod2_q[IDX_W+QS-1:QS];
    rem = idx2_q - IDX_W'(32'(q0) * 32'(Z_POINTS));
    fix = (32'(rem) >= 32'(Z_POINTS));
    lr  = fix ? (q0 + 1'b1) : q0;
    lz  = fix ? (rem - IDX_W'(Z_POINTS)) : rem;
    lok = (32'(idx2_q) < 32'(DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      rcell3_q <= rcell;
      zcell3_q <= zcell;
      rc3_q    <= rc2_q;
      zc3_q    <= zc2_q;
      cmd3_q   <= cmd2_q;
      lr3_q    <= lr[RW-1:0];
      lz3_q    <= lz[ZW-1:0];
      lok3_q   <= lok;
      ent3_q   <= ent2_q;
    end
  end

  // stage 4: corners spread over four banks by (r, z) parity
  logic [RW-1:0]            rp;
  logic [ZW-1:0]            zp;
  logic [1:0]               wbank;
  logic                     go4;
  logic signed [ZW:0]       zoff;

  always_comb begin
    rp = '0;
    zp = '0;
    for (int b = 0; b < 4; b++) begin
      rp = rcell3_q + RW'(1'(b >> 1) ^ rcell3_q[0]);
      zp = zcell3_q + ZW'(1'(b) ^ zcell3_q[0]);
      raddr_o[b] = AW'((32'(rp) >> 1) * 32'(ZH) + (32'(zp) >> 1));
    end
    waddr_o  = AW'((32'(lr3_q) >> 1) * 32'(ZH) + (32'(lz3_q) >> 1));
    wbank    = {lr3_q[0], lz3_q[0]};
    go4      = ctrl_i.vld[STG_MEM-1] && ctrl_i.en[STG_MEM];
    ram_o.re = go4 && cmd3_q;
    for (int b = 0; b < 4; b++) begin
      ram_o.we[b] = go4 && !cmd3_q && lok3_q && (wbank == 2'(b));
    end
    zoff = $signed({1'b0, zcell3_q}) - (ZW+1)'(HALF);
  end

  assign wdata_o = ent3_q;
  assign lkp3_o  = cmd3_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[STG_MEM]) begin
      pos_r_o <= $signed(GEO_W'(rc3_q));
      pos_z_o <= GEO_W'(zc3_q);
      low_r_o <= $signed(GEO_W'(rcell3_q) * GEO_W'(r_step_i));
      low_z_o <= GEO_W'(zoff) * $signed(GEO_W'(z_step_i));
      par_o   <= {rcell3_q[0], zcell3_q[0]};
    end
  end
endmodule

// ===== design/rzfm_blend.sv =====
// ----------------------------------------------------------------------------
// rzfm_blend
// offsets, area weights, weighted corner sum and normalization
// ----------------------------------------------------------------------------
module rzfm_blend (
  input  logic                              clk_i,
  input  rzfm_pkg::pipe_ctrl_t              ctrl_i,
  input  logic signed [rzfm_pkg::GEO_W-1:0] pos_r_i,
  input  logic signed [rzfm_pkg::GEO_W-1:0] pos_z_i,
  input  logic signed [rzfm_pkg::GEO_W-1:0] low_r_i,
  input  logic signed [rzfm_pkg::GEO_W-1:0] low_z_i,
  input  logic [1:0]                        par_i,
  input  rzfm_pkg::quad_t                   bank_i,
  input  logic [rzfm_pkg::STEP_W-1:0]       r_step_i,
  input  logic [rzfm_pkg::STEP_W-1:0]       z_step_i,
  input  logic [rzfm_pkg::AREA_W-1:0]       area_i,
  output rzfm_pkg::fld3_t                   res_o
);
  import rzfm_pkg::*;

  // stage 5: offsets inside the cell, corners back in (r, z) order
  logic signed [GEO_W-1:0] dr_raw, dz_raw, rs_s, zs_s;
  logic [STEP_W-1:0]       dr5_q, dz5_q;
  quad_t                   cdat5_q;

  always_comb begin
    dr_raw = pos_r_i - low_r_i;
    dz_raw = pos_z_i - low_z_i;
    rs_s   = $signed(GEO_W'(r_step_i));
    zs_s   = $signed(GEO_W'(z_step_i));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      dr5_q <= (dr_raw < 0) ? '0 : ((dr_raw > rs_s) ? r_step_i : dr_raw[STEP_W-1:0]);
      dz5_q <= (dz_raw < 0) ? '0 : ((dz_raw > zs_s) ? z_step_i : dz_raw[STEP_W-1:0]);
      for (int k = 0; k < 4; k++) begin
        cdat5_q[k] <= bank_i[{par_i[1] ^ 1'(k >> 1), par_i[0] ^ 1'(k)}];
      end
    end
  end

  // stage 6: area weights
  logic [STEP_W-1:0]  rr, zz;
  logic [AREA_W-1:0]  w6_q [4];
  quad_t              cdat6_q;

  always_comb begin
    rr = r_step_i - dr5_q;
    zz = z_step_i - dz5_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      w6_q[0] <= AREA_W'(rr) * AREA_W'(zz);
      w6_q[1] <= AREA_W'(rr) * AREA_W'(dz5_q);
      w6_q[2] <= AREA_W'(dr5_q) * AREA_W'(zz);
      w6_q[3] <= AREA_W'(dr5_q) * AREA_W'(dz5_q);
      cdat6_q <= cdat5_q;
    end
  end

  // stage 7: entry times weight as two 32x24 partial products
  logic signed [56:0] lo7_q [3][4];
  logic signed [56:0] hi7_q [3][4];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          lo7_q[c][k] <= 57'($signed(cdat6_q[k][c])) *
                         57'($signed({1'b0, w6_q[k][23:0]}));
          hi7_q[c][k] <= 57'($signed(cdat6_q[k][c])) *
                         57'($signed({1'b0, w6_q[k][47:24]}));
        end
      end
    end
  end

  // stages 8 to 10: terms and corner sum
  logic signed [80:0] term8_q [3][4];
  logic signed [81:0] pair9_q [3][2];
  logic signed [82:0] sum10_q [3];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[8]) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          term8_q[c][k] <= (81'(hi7_q[c][k]) <<< 24) + 81'(lo7_q[c][k]);
        end
      end
    end
    if (ctrl_i.en[9]) begin
      for (int c = 0; c < 3; c++) begin
        pair9_q[c][0] <= 82'(term8_q[c][0]) + 82'(term8_q[c][1]);
        pair9_q[c][1] <= 82'(term8_q[c][2]) + 82'(term8_q[c][3]);
      end
    end
    if (ctrl_i.en[10]) begin
      for (int c = 0; c < 3; c++) begin
        sum10_q[c] <= 83'(pair9_q[c][0]) + 83'(pair9_q[c][1]);
      end
    end
  end

  // stage 11: sign and magnitude
  logic signed [82:0] sum_neg [3];
  logic [79:0]        mag11_q [3];
  logic [2:0]         neg11_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_neg[c] = -sum10_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[11]) begin
      for (int c = 0; c < 3; c++) begin
        neg11_q[c] <= sum10_q[c][82];
        mag11_q[c] <= sum10_q[c][82] ? sum_neg[c][79:0] : sum10_q[c][79:0];
      end
    end
  end

  // stage 12: magnitude times area reciprocal in 27x24 pieces
  logic [26:0] mchunk [3][3];
  logic [50:0] p12_q  [3][3][2];
  logic [2:0]  neg12_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mchunk[c][0] = mag11_q[c][26:0];
      mchunk[c][1] = mag11_q[c][53:27];
      mchunk[c][2] = {1'b0, mag11_q[c][79:54]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[12]) begin
      neg12_q <= neg11_q;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          p12_q[c][i][0] <= 51'(mchunk[c][i]) * 51'(area_i[23:0]);
          p12_q[c][i][1] <= 51'(mchunk[c][i]) * 51'(area_i[47:24]);
        end
      end
    end
  end

  // stages 13 to 15: partial product sum
  logic [127:0] x13_q [3];
  logic [127:0] y13_q [3];
  logic [50:0]  xh13_q [3];
  logic [50:0]  yh13_q [3];
  logic [127:0] x14_q [3];
  logic [127:0] y14_q [3];
  logic [127:0] p15_q [3];
  logic [2:0]   neg13_q, neg14_q, neg15_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[13]) begin
      neg13_q <= neg12_q;
      for (int c = 0; c < 3; c++) begin
        x13_q[c]  <= 128'(p12_q[c][0][0]) + (128'(p12_q[c][1][0]) << 27);
        y13_q[c]  <= 128'(p12_q[c][0][1]) + (128'(p12_q[c][1][1]) << 27);
        xh13_q[c] <= p12_q[c][2][0];
        yh13_q[c] <= p12_q[c][2][1];
      end
    end
    if (ctrl_i.en[14]) begin
      neg14_q <= neg13_q;
      for (int c = 0; c < 3; c++) begin
        x14_q[c] <= x13_q[c] + (128'(xh13_q[c]) << 54);
        y14_q[c] <= y13_q[c] + (128'(yh13_q[c]) << 54);
      end
    end
    if (ctrl_i.en[15]) begin
      neg15_q <= neg14_q;
      for (int c = 0; c < 3; c++) begin
        p15_q[c] <= x14_q[c] + (y14_q[c] << 24);
      end
    end
  end

  // stage 16: drop 48 fraction bits, negative values round away from zero
  logic [80:0] q16_q [3];
  logic [2:0]  neg16_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[16]) begin
      neg16_q <= neg15_q;
      for (int c = 0; c < 3; c++) begin
        q16_q[c] <= 81'(p15_q[c][127:48]) +
                    81'(neg15_q[c] && (p15_q[c][47:0] != '0));
      end
    end
  end

  // stage 17: saturate and restore sign
  fld3_t res17_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[NSTG]) begin
      for (int c = 0; c < 3; c++) begin
        if (neg16_q[c]) begin
          res17_q[c] <= (q16_q[c] >= 81'h8000_0000) ? FLD_MIN : (~q16_q[c][31:0] + 32'd1);
        end else begin
          res17_q[c] <= (q16_q[c] > 81'(FLD_MAX)) ? FLD_MAX : q16_q[c][31:0];
        end
      end
    end
  end

  assign res_o = res17_q;
endmodule
